### hw/rtl/plidf_pkg.sv
`default_nettype none

package plidf_pkg;

  localparam int unsigned REQ_W = 2;
  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
  } eng_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } eng_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/positional_list_insert_delete_find.sv
// Positional list of signed 32-bit values held in an on-chip memory.
// A request is taken at a clock edge where start is high and busy is low:
// in_req_type selects insert, delete, find or clear, in_position is the
// 1-based place for insert and delete, in_value the value to insert or find.
// Every request gives exactly one result beat: out_valid is high for one
// cycle with out_status, out_found_position and out_list_length.
// Busy drops as the result beat appears, so the next request can be taken
// at the edge that takes that beat.
// Clear, a rejected position, a full store and find on an empty list answer
// one cycle after the request and leave busy low.
// Insert moves the entries from the position to the end up one slot, one
// entry per cycle through the single memory port pair, then writes the new
// value; appending at the end writes only the value. Delete moves the tail
// down; removing the last entry moves nothing. Find reads entries from the
// head one per cycle and stops at the first match, or answers not found
// after the last entry.
// Reset empties the list at once; the memory is not cleared and needs no
// sweep. The receiver cannot stall, so a result beat is never held.
`default_nettype none

module positional_list_insert_delete_find #(
  parameter int unsigned LIST_DEPTH = 128
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire        [1:0]  in_req_type,
  input  wire        [7:0]  in_position,
  input  wire signed [31:0] in_value,
  output logic              out_valid,
  output logic       [1:0]  out_status,
  output logic       [7:0]  out_found_position,
  output logic       [7:0]  out_list_length
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned LW = $clog2(LIST_DEPTH+1);
  localparam int unsigned CW = ((LW > plidf_pkg::POS_W) ? LW : plidf_pkg::POS_W) + 1;

  logic                 busy_r, busy_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  plidf_pkg::op_t       op_r, op_nxt;
  logic                 ov_r, ov_nxt;
  plidf_pkg::status_t   st_r, st_nxt;
  logic [7:0]           fpos_r, fpos_nxt;
  logic [7:0]           olen_r, olen_nxt;

  logic                 accept;
  logic [CW-1:0]        pos_w;
  logic [CW-1:0]        len_w;
  logic [CW-1:0]        len_inc_w;
  logic [CW-1:0]        len_dec_w;
  logic                 go;
  plidf_pkg::eng_cmd_t  cmd;
  logic [AW-1:0]        idx;
  plidf_pkg::eng_rsp_t  rsp;
  logic [AW-1:0]        found_idx;
  logic [CW-1:0]        fpos_w;

  assign accept    = start && !busy_r;
  assign pos_w     = CW'(in_position);
  assign len_w     = CW'(len_r);
  assign len_inc_w = len_w + CW'(1);
  assign len_dec_w = len_w - CW'(1);
  assign idx       = AW'(pos_w - CW'(1));
  assign fpos_w    = CW'(found_idx) + CW'(1);

  always_comb begin
    busy_nxt  = busy_r;
    len_nxt   = len_r;
    op_nxt    = op_r;
    ov_nxt    = 1'b0;
    st_nxt    = st_r;
    fpos_nxt  = fpos_r;
    olen_nxt  = olen_r;
    go        = 1'b0;
    cmd.op    = plidf_pkg::OP_FIND;
    cmd.value = in_value;
    if (accept) begin
      fpos_nxt = '0;
      olen_nxt = len_w[7:0];
      case (in_req_type)
        plidf_pkg::REQ_INSERT: begin
          cmd.op = plidf_pkg::OP_INSERT;
          if ((pos_w == '0) || (pos_w > (len_w + CW'(1)))) begin
            ov_nxt = 1'b1;
            st_nxt = plidf_pkg::ST_BADPOS;
          end else if (len_r == LW'(LIST_DEPTH)) begin
            ov_nxt = 1'b1;
            st_nxt = plidf_pkg::ST_FULL;
          end else begin
            go       = 1'b1;
            busy_nxt = 1'b1;
            op_nxt   = plidf_pkg::OP_INSERT;
          end
        end
        plidf_pkg::REQ_DELETE: begin
          cmd.op = plidf_pkg::OP_DELETE;
          if ((pos_w == '0) || (pos_w > len_w)) begin
            ov_nxt = 1'b1;
            st_nxt = plidf_pkg::ST_BADPOS;
          end else begin
            go       = 1'b1;
            busy_nxt = 1'b1;
            op_nxt   = plidf_pkg::OP_DELETE;
          end
        end
        plidf_pkg::REQ_FIND: begin
          cmd.op = plidf_pkg::OP_FIND;
          if (len_r == '0) begin
            ov_nxt = 1'b1;
            st_nxt = plidf_pkg::ST_NOTFOUND;
          end else begin
            go       = 1'b1;
            busy_nxt = 1'b1;
            op_nxt   = plidf_pkg::OP_FIND;
          end
        end
        default: begin
          len_nxt  = '0;
          olen_nxt = '0;
          ov_nxt   = 1'b1;
          st_nxt   = plidf_pkg::ST_OK;
        end
      endcase
    end else if (busy_r && rsp.done) begin
      busy_nxt = 1'b0;
      ov_nxt   = 1'b1;
      st_nxt   = plidf_pkg::ST_OK;
      fpos_nxt = '0;
      case (op_r)
        plidf_pkg::OP_INSERT: begin
          len_nxt  = len_r + LW'(1);
          olen_nxt = len_inc_w[7:0];
        end
        plidf_pkg::OP_DELETE: begin
          len_nxt  = len_r - LW'(1);
          olen_nxt = len_dec_w[7:0];
        end
        default: begin
          olen_nxt = len_w[7:0];
          if (rsp.found) begin
            fpos_nxt = fpos_w[7:0];
          end else begin
            st_nxt = plidf_pkg::ST_NOTFOUND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      len_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      len_r  <= len_nxt;
      ov_r   <= ov_nxt;
    end
    op_r   <= op_nxt;
    st_r   <= st_nxt;
    fpos_r <= fpos_nxt;
    olen_r <= olen_nxt;
  end

  plidf_walk #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .cmd       (cmd),
    .idx       (idx),
    .len       (len_r),
    .rsp       (rsp),
    .found_idx (found_idx)
  );

  assign busy               = busy_r;
  assign out_valid          = ov_r;
  assign out_status         = st_r;
  assign out_found_position = fpos_r;
  assign out_list_length    = olen_r;

endmodule

`default_nettype wire

### hw/rtl/plidf_walk.sv
`default_nettype none

module plidf_walk #(
  parameter int unsigned LIST_DEPTH = 128
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   go,
  input  wire  plidf_pkg::eng_cmd_t             cmd,
  input  wire  [$clog2(LIST_DEPTH)-1:0]         idx,
  input  wire  [$clog2(LIST_DEPTH+1)-1:0]       len,
  output plidf_pkg::eng_rsp_t                   rsp,
  output logic [$clog2(LIST_DEPTH)-1:0]         found_idx
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned LW = $clog2(LIST_DEPTH+1);
  localparam int unsigned VW = plidf_pkg::VAL_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INS   = 7'b0000010,
    S_DEL   = 7'b0000100,
    S_FIND  = 7'b0001000,
    S_FEND  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_t;

  logic [VW-1:0] mem [LIST_DEPTH];

  state_t          state_r, state_nxt;
  plidf_pkg::op_t  op_r, op_nxt;
  logic [VW-1:0]   val_r, val_nxt;
  logic [AW-1:0]   p_r, p_nxt;
  logic [AW-1:0]   last_r, last_nxt;
  logic [AW-1:0]   ra_r, ra_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;
  logic            pv_r;
  logic [VW-1:0]   rd_data_r;
  logic            done_r, done_nxt;
  logic            found_r, found_nxt;
  logic [AW-1:0]   fidx_r, fidx_nxt;

  logic            re;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [VW-1:0]   wdata;
  logic            hit;

  assign re  = (state_r == S_INS) || (state_r == S_DEL) || (state_r == S_FIND);
  assign hit = pv_r && (rd_data_r == val_r);

  always_comb begin
    we    = 1'b0;
    waddr = wa_r;
    wdata = rd_data_r;
    case (state_r)
      S_INS, S_DEL, S_DRAIN: begin
        we = pv_r && (op_r != plidf_pkg::OP_FIND);
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = p_r;
        wdata = val_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[ra_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    p_nxt     = p_r;
    last_nxt  = last_r;
    ra_nxt    = ra_r;
    wa_nxt    = wa_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          op_nxt    = cmd.op;
          val_nxt   = cmd.value;
          p_nxt     = idx;
          found_nxt = 1'b0;
          case (cmd.op)
            plidf_pkg::OP_INSERT: begin
              ra_nxt   = AW'(len - LW'(1));
              last_nxt = idx;
              if (len == LW'(idx)) begin
                state_nxt = S_WRITE;
              end else begin
                state_nxt = S_INS;
              end
            end
            plidf_pkg::OP_DELETE: begin
              ra_nxt   = AW'(idx + AW'(1));
              last_nxt = AW'(len - LW'(1));
              if ((LW'(idx) + LW'(1)) == len) begin
                done_nxt = 1'b1;
              end else begin
                state_nxt = S_DEL;
              end
            end
            default: begin
              ra_nxt    = '0;
              last_nxt  = AW'(len - LW'(1));
              state_nxt = S_FIND;
            end
          endcase
        end
      end
      S_INS: begin
        wa_nxt = ra_r + AW'(1);
        ra_nxt = ra_r - AW'(1);
        if (ra_r == last_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DEL: begin
        wa_nxt = ra_r - AW'(1);
        ra_nxt = ra_r + AW'(1);
        if (ra_r == last_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_FIND: begin
        if (hit) begin
          done_nxt  = 1'b1;
          found_nxt = 1'b1;
          fidx_nxt  = wa_r;
          state_nxt = S_IDLE;
        end else begin
          wa_nxt = ra_r;
          ra_nxt = ra_r + AW'(1);
          if (ra_r == last_r) begin
            state_nxt = S_FEND;
          end
        end
      end
      S_FEND: begin
        done_nxt  = 1'b1;
        found_nxt = hit;
        fidx_nxt  = wa_r;
        state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        if (op_r == plidf_pkg::OP_INSERT) begin
          state_nxt = S_WRITE;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WRITE: begin
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= re;
      done_r  <= done_nxt;
    end
    op_r    <= op_nxt;
    val_r   <= val_nxt;
    p_r     <= p_nxt;
    last_r  <= last_nxt;
    ra_r    <= ra_nxt;
    wa_r    <= wa_nxt;
    found_r <= found_nxt;
    fidx_r  <= fidx_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.found = found_r;
  assign found_idx = fidx_r;

endmodule

`default_nettype wire
